[hdl/life_cellular_automaton_engine_assert.svh]
// Assertion helpers shared by the engine RTL.
`ifndef LIFE_CELLULAR_AUTOMATON_ENGINE_ASSERT_SVH
`define LIFE_CELLULAR_AUTOMATON_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lce assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lce assertion failed");

`endif

[hdl/lce_pkg.sv]
package lce_pkg;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int LIVE_W = 13;
    localparam int GEN_W  = 32;
    localparam int NBR_W  = 4;

    // Operation codes; the spare code behaves as a read
    localparam logic [1:0] MODE_TOGGLE = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_STEP   = 2'd2;

    // B3/S23 rule constants
    localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

    localparam logic [LIVE_W-1:0] LIVE_MAX = 13'h1FFF;

    typedef struct packed {
        logic [1:0]       mode;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
    } lce_in_t;

    typedef struct packed {
        logic              cell_value;
        logic [LIVE_W-1:0] live_count;
        logic [GEN_W-1:0]  generation_count;
    } lce_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_MODIFY,
        ST_LOAD0,
        ST_LOAD1,
        ST_LOAD2,
        ST_CELL,
        ST_ROWEND,
        ST_ROWLOAD,
        ST_DONE
    } lce_state_t;

endpackage

[hdl/life_cellular_automaton_engine.sv]
// Game of Life engine (B3/S23) on a GRID_ROWS x GRID_COLUMNS grid, dead beyond the edges.
// The grid sits in a RAM with one row per word. Every input beat returns one result
// beat. Toggle and read fetch the addressed row word (ST_ACCESS, ST_MODIFY), a toggle writes
// it back with the cell flipped, and ST_DONE loads the result before the engine returns to idle.
// A step primes the row window in ST_LOAD0, ST_LOAD1 and ST_LOAD2, then one rule evaluator
// visits one cell per cycle; after each row the new row is written back and, for every row
// but the last, the next row is brought in from the RAM, and ST_DONE loads the result.
// A result held off by m_ready can hold the next beat in ST_DONE until it is taken.
// After reset a clearing pass writes every row of the grid dead; no beat is
// accepted during it. A finished result waits in an output register, and the next beat
// may be accepted while it is still pending.
`include "life_cellular_automaton_engine_assert.svh"

module life_cellular_automaton_engine #(
    parameter int GRID_ROWS    = 64,
    parameter int GRID_COLUMNS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lce_pkg::lce_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lce_pkg::lce_out_t  m_data
);

    import lce_pkg::*;

    localparam int RA_W = $clog2(GRID_ROWS);
    localparam int CI_W = $clog2(GRID_COLUMNS);

    lce_state_t              state_reg, state_next;
    lce_in_t                 req_reg, req_next;
    logic [RA_W-1:0]         clr_addr_reg, clr_addr_next;
    logic [RA_W-1:0]         row_cnt_reg, row_cnt_next;
    logic [CI_W-1:0]         col_cnt_reg, col_cnt_next;
    logic [GRID_COLUMNS-1:0] prev_reg, prev_next;
    logic [GRID_COLUMNS-1:0] cur_reg, cur_next;
    logic [GRID_COLUMNS-1:0] nxt_reg, nxt_next;
    logic [GRID_COLUMNS-1:0] new_row_reg, new_row_next;
    logic [LIVE_W-1:0]       live_acc_reg, live_acc_next;
    logic [LIVE_W-1:0]       live_total_reg, live_total_next;
    logic [GEN_W-1:0]        gen_reg, gen_next;
    logic                    result_bit_reg, result_bit_next;
    logic                    m_valid_reg, m_valid_next;
    lce_out_t                m_data_reg, m_data_next;

    logic                    ram_we;
    logic [RA_W-1:0]         ram_waddr;
    logic [GRID_COLUMNS-1:0] ram_wdata;
    logic [RA_W-1:0]         ram_raddr;
    logic [GRID_COLUMNS-1:0] ram_rdata;

    logic                    in_grid;
    logic [RA_W-1:0]         req_row_addr;
    logic [CI_W-1:0]         req_col;
    logic [GRID_COLUMNS+1:0] pad_prev, pad_cur, pad_nxt;
    logic [2:0]              win_prev, win_cur, win_nxt;
    logic [NBR_W-1:0]        nbr_count;
    logic                    next_bit;

    lce_ram #(
        .WIDTH(GRID_COLUMNS),
        .DEPTH(GRID_ROWS)
    ) u_grid_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // Decode the addressed cell
    assign in_grid      = (int'(req_reg.row) < GRID_ROWS) && (int'(req_reg.column) < GRID_COLUMNS);
    assign req_row_addr = RA_W'(req_reg.row);
    assign req_col      = CI_W'(req_reg.column);

    // Take the 3x3 window around the current column, zero beyond the side edges
    assign pad_prev = {1'b0, prev_reg, 1'b0};
    assign pad_cur  = {1'b0, cur_reg, 1'b0};
    assign pad_nxt  = {1'b0, nxt_reg, 1'b0};
    assign win_prev = pad_prev[col_cnt_reg +: 3];
    assign win_cur  = pad_cur[col_cnt_reg +: 3];
    assign win_nxt  = pad_nxt[col_cnt_reg +: 3];

    // Count neighbours and apply the rule
    assign nbr_count = {3'b000, win_prev[0]} + {3'b000, win_prev[1]} + {3'b000, win_prev[2]}
                     + {3'b000, win_cur[0]}  + {3'b000, win_cur[2]}
                     + {3'b000, win_nxt[0]}  + {3'b000, win_nxt[1]}  + {3'b000, win_nxt[2]};
    assign next_bit  = (nbr_count == BIRTH_COUNT) || (win_cur[1] && (nbr_count == SURVIVE_COUNT));

    // Sequence the operations and drive the RAM
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        clr_addr_next   = clr_addr_reg;
        row_cnt_next    = row_cnt_reg;
        col_cnt_next    = col_cnt_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        new_row_next    = new_row_reg;
        live_acc_next   = live_acc_reg;
        live_total_next = live_total_reg;
        gen_next        = gen_reg;
        result_bit_next = result_bit_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = row_cnt_reg;
        ram_wdata       = new_row_reg;
        ram_raddr       = req_row_addr;
        s_ready         = 1'b0;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == RA_W'(GRID_ROWS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + RA_W'(1);
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = (s_data.mode == MODE_STEP) ? ST_LOAD0 : ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                ram_raddr  = req_row_addr;
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (req_reg.mode == MODE_TOGGLE && in_grid) begin
                    ram_we    = 1'b1;
                    ram_waddr = req_row_addr;
                    ram_wdata = ram_rdata ^ (GRID_COLUMNS'(1) << req_col);
                end
                result_bit_next = in_grid
                                & (ram_rdata[req_col] ^ (req_reg.mode == MODE_TOGGLE));
                state_next      = ST_DONE;
            end
            ST_LOAD0: begin
                ram_raddr       = '0;
                live_acc_next   = '0;
                result_bit_next = 1'b0;
                state_next      = ST_LOAD1;
            end
            ST_LOAD1: begin
                cur_next   = ram_rdata;
                prev_next  = '0;
                ram_raddr  = RA_W'(1);
                state_next = ST_LOAD2;
            end
            ST_LOAD2: begin
                nxt_next     = ram_rdata;
                row_cnt_next = '0;
                col_cnt_next = '0;
                state_next   = ST_CELL;
            end
            ST_CELL: begin
                new_row_next[col_cnt_reg] = next_bit;
                if (next_bit && live_acc_reg != LIVE_MAX) begin
                    live_acc_next = live_acc_reg + LIVE_W'(1);
                end
                if (col_cnt_reg == CI_W'(GRID_COLUMNS - 1)) begin
                    state_next = ST_ROWEND;
                end else begin
                    col_cnt_next = col_cnt_reg + CI_W'(1);
                end
            end
            ST_ROWEND: begin
                // Write the new row back and fetch the row two below
                ram_we    = 1'b1;
                ram_waddr = row_cnt_reg;
                ram_wdata = new_row_reg;
                ram_raddr = row_cnt_reg + RA_W'(2);
                if (in_grid && row_cnt_reg == req_row_addr) begin
                    result_bit_next = new_row_reg[req_col];
                end
                prev_next = cur_reg;
                cur_next  = nxt_reg;
                if (row_cnt_reg == RA_W'(GRID_ROWS - 1)) begin
                    live_total_next = live_acc_reg;
                    gen_next        = gen_reg + GEN_W'(1);
                    state_next      = ST_DONE;
                end else begin
                    row_cnt_next = row_cnt_reg + RA_W'(1);
                    state_next   = ST_ROWLOAD;
                end
            end
            ST_ROWLOAD: begin
                nxt_next     = (int'(row_cnt_reg) + 1 < GRID_ROWS) ? ram_rdata : '0;
                col_cnt_next = '0;
                state_next   = ST_CELL;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                 = 1'b1;
                    m_data_next.cell_value       = result_bit_reg;
                    m_data_next.live_count       = live_total_reg;
                    m_data_next.generation_count = gen_reg;
                    state_next                   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state and counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
            live_total_reg <= '0;
            gen_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            m_valid_reg    <= m_valid_next;
            live_total_reg <= live_total_next;
            gen_reg        <= gen_next;
        end
    end

    // Advance the datapath registers
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        row_cnt_reg    <= row_cnt_next;
        col_cnt_reg    <= col_cnt_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        nxt_reg        <= nxt_next;
        new_row_reg    <= new_row_next;
        live_acc_reg   <= live_acc_next;
        result_bit_reg <= result_bit_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `LCE_ASSERT_NEXT(a_done_loads_result, aclk, aresetn, (state_reg == ST_DONE) && (!m_valid_reg || m_ready), m_valid_reg)
    `LCE_ASSERT_NEXT(a_gen_only_on_step, aclk, aresetn, state_reg != ST_ROWEND, $stable(gen_reg))
    `LCE_ASSERT_NEXT(a_gen_advances, aclk, aresetn, (state_reg == ST_ROWEND) && (row_cnt_reg == RA_W'(GRID_ROWS - 1)), gen_reg == $past(gen_reg) + 32'd1)
    `LCE_ASSERT_IMP(a_no_accept_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_ready)

endmodule

[hdl/lce_ram.sv]
module lce_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
